>>> src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared definitions for the websocket frame deframer
// Length width, result kinds, result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   // width kept for the decoded payload length (16..64)
   localparam int LENGTH_WIDTH = 64;
   // bit 63 of a 64-bit length is always dropped
   localparam int LEN_W        = (LENGTH_WIDTH >= 63) ? 63 : LENGTH_WIDTH;
   localparam int OUT_LEN_W    = 63;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // result tdata width: 81 field bits padded to whole bytes
   localparam int RSP_DATA_W = 88;

   // one result beat
   typedef struct packed {
      logic [1:0]           kind;
      logic                 fin;
      logic [3:0]           opcode;
      logic                 masked;
      logic [OUT_LEN_W-1:0] payload_length;
      logic [3:0]           header_bytes;
      logic [7:0]           payload_byte;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: websocket frame header decode and payload unmask
// Takes one received byte per beat, emits a header beat, unmasked payload
// beats and a truncation error beat at buffer end.
// ----------------------------------------------------------------------------
// Result beats are registered in the result queue and presented from its head.
// Throughput: one byte per cycle; the four-entry result queue takes the up to
// two results of a byte in one cycle and req_tready drops only while fewer
// than two entries are free.
// Reset: synchronous, active high; decoder returns to awaiting the first
// header byte, the result queue is emptied.
`default_nettype none

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte input
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // rx_byte[7:0]
   input  wire logic                  req_tlast,   // end_of_data
   // result output
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // fin[0], opcode[4:1], masked[5], payload_length[68:6],
   // header_bytes[72:69], payload_byte[80:73], zero[87:81]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser,   // kind[1:0]
   output logic                       rsp_tlast    // last
);

   // decoder phases
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // decoder state
   logic [2:0]       phase_ff, phase_in;
   logic [3:0]       hcount_ff, hcount_in;
   logic             fin_ff, fin_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [31:0]      key_ff, key_in;
   logic [LEN_W-1:0] pcount_ff, pcount_in;

   // result queue
   rsp_type          queue_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   logic             accept;
   logic             pop;
   logic             emit_hdr;
   logic             emit_pay;
   logic             emit_err;
   logic             pay_last;
   logic [7:0]       key_byte;
   logic [7:0]       pay_byte;
   logic [LEN_W-1:0] pcount_inc;
   logic [1:0]       push_n;
   rsp_type          hdr_beat;
   rsp_type          pay_beat;
   rsp_type          err_beat;
   rsp_type          first_beat;
   rsp_type          head;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign pcount_inc = pcount_ff + LEN_W'(1);

   // key byte for this payload index, first key byte in the top bits
   always_comb begin
      unique case (pcount_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign pay_byte = req_tdata ^ (mask_ff ? key_byte : 8'h00);

   // frame decode for one accepted byte
   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      length_in = length_ff;
      key_in    = key_ff;
      pcount_in = pcount_ff;
      emit_hdr  = 1'b0;
      emit_pay  = 1'b0;
      pay_last  = 1'b0;
      emit_err  = 1'b0;
      hdr_beat  = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_tdata[7];
               opcode_in = req_tdata[3:0];
               hcount_in = 4'd1;
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in   = req_tdata[7];
               hcount_in = 4'd2;
               length_in = '0;
               if (req_tdata[6:0] == LEN_CODE_16) begin
                  phase_in = PH_EXT16;
               end else if (req_tdata[6:0] == LEN_CODE_64) begin
                  phase_in = PH_EXT64;
               end else begin
                  length_in = LEN_W'(req_tdata[6:0]);
                  if (mask_in) begin
                     phase_in  = PH_MASK;
                     pcount_in = '0;
                  end else begin
                     emit_hdr = 1'b1;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               length_in = {length_ff[LEN_W-9:0], req_tdata};
               hcount_in = hcount_ff + 4'd1;
               if ((phase_ff == PH_EXT16 && hcount_in == 4'd4) ||
                   (phase_ff == PH_EXT64 && hcount_in == 4'd10)) begin
                  if (mask_ff) begin
                     phase_in  = PH_MASK;
                     pcount_in = '0;
                  end else begin
                     emit_hdr = 1'b1;
                  end
               end
            end
            PH_MASK: begin
               key_in    = {key_ff[23:0], req_tdata};
               hcount_in = hcount_ff + 4'd1;
               pcount_in = pcount_inc;
               if (pcount_inc >= LEN_W'(4)) begin
                  emit_hdr = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               emit_pay  = 1'b1;
               pcount_in = pcount_inc;
               if (pcount_inc == length_ff) begin
                  pay_last = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase

         // header complete: report it and move on to the payload, or to done if empty
         if (emit_hdr) begin
            hdr_beat.kind           = KIND_HEADER;
            hdr_beat.fin            = fin_in;
            hdr_beat.opcode         = opcode_in;
            hdr_beat.masked         = mask_in;
            hdr_beat.payload_length = OUT_LEN_W'(length_in);
            hdr_beat.header_bytes   = hcount_in;
            hdr_beat.last           = (length_in == '0);
            pcount_in = '0;
            phase_in  = (length_in == '0) ? PH_DONE : PH_PAYLOAD;
         end

         // buffer end: flag an unfinished frame, then back to reset state
         if (req_tlast) begin
            emit_err  = (phase_in <= PH_PAYLOAD);
            phase_in  = PH_HDR0;
            hcount_in = '0;
            fin_in    = 1'b0;
            opcode_in = '0;
            mask_in   = 1'b0;
            length_in = '0;
            key_in    = '0;
            pcount_in = '0;
         end
      end
   end

   // result beats
   always_comb begin
      pay_beat              = '0;
      pay_beat.kind         = KIND_PAYLOAD;
      pay_beat.payload_byte = pay_byte;
      pay_beat.last         = pay_last;
      err_beat              = '0;
      err_beat.kind         = KIND_ERROR;
   end

   always_comb begin
      priority if (emit_hdr) begin
         first_beat = hdr_beat;
      end else if (emit_pay) begin
         first_beat = pay_beat;
      end else begin
         first_beat = err_beat;
      end
   end

   assign push_n = 2'(emit_hdr || emit_pay) + 2'(emit_err);

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push_n) - 3'(pop);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hcount_ff <= '0;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         length_ff <= '0;
         key_ff    <= '0;
         pcount_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         key_ff    <= key_in;
         pcount_ff <= pcount_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries, up to two written per cycle
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_beat;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= err_beat;
      end
   end

   // output side
   assign head       = queue_ff[rd_ptr_ff];
   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {7'd0, head.payload_byte, head.header_bytes, head.payload_length,
                        head.masked, head.opcode, head.fin};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule

`default_nettype wire
